/* rtl/tgarle_pkg.sv */
`timescale 1ns / 1ps

package tgarle_pkg;

  localparam int DIM_BITS = 16;
  localparam int CFG_W    = 16;
  localparam int Q_DEPTH  = 2;
  localparam int Q_AW     = $clog2(Q_DEPTH);

  localparam logic [1:0] FMT_GRAY = 2'd0;
  localparam logic [1:0] FMT_BGR  = 2'd1;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_RLE    = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [7:0] RUN_BASE = 8'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_data_t;

  typedef struct packed {
    logic [31:0] first_pixel;
    logic [31:0] second_pixel;
    logic [1:0]  pixel_count;
    logic        first_ends_row;
    logic        second_ends_row;
    logic        image_done;
    logic        last_of_run;
  } out_data_t;

  typedef struct packed {
    logic [1:0]          pixel_format;
    logic                run_length_coded;
    logic [DIM_BITS-1:0] image_width;
    logic [DIM_BITS-1:0] image_height;
  } cfg_t;

  // One entry per queued beat: clear of position state, pixel and repeat count.
  typedef struct packed {
    logic        clear;
    logic [31:0] pix;
    logic [7:0]  count;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

endpackage

/* rtl/tgarle_front.sv */
`timescale 1ns / 1ps

module tgarle_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tgarle_pkg::in_data_t in_data,
  input  tgarle_pkg::cfg_t     cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output tgarle_pkg::job_t     q_job
);
  import tgarle_pkg::*;

  logic        hdr_wait_r, hdr_wait_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic        rpt_r, rpt_nxt;
  logic [31:0] coll_r, coll_nxt;
  logic [1:0]  bip_r, bip_nxt;

  logic        accept;
  logic        hdr_wait_c, rpt_c;
  logic [7:0]  rem_c, b;
  logic [31:0] coll_c, c_new, pix;
  logic [1:0]  bip_c, need_m1;
  logic        formed;
  job_t        job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;

  // frame_start wipes the decode state before this beat is used
  assign hdr_wait_c = in_data.frame_start ? 1'b1  : hdr_wait_r;
  assign rem_c      = in_data.frame_start ? 8'd0  : rem_r;
  assign rpt_c      = in_data.frame_start ? 1'b0  : rpt_r;
  assign coll_c     = in_data.frame_start ? 32'd0 : coll_r;
  assign bip_c      = in_data.frame_start ? 2'd0  : bip_r;

  always_comb begin
    case (cfg.pixel_format)
      FMT_GRAY: need_m1 = 2'd0;
      FMT_BGR:  need_m1 = 2'd2;
      default:  need_m1 = 2'd3;
    endcase
  end

  assign c_new  = coll_c | (32'(b) << {bip_c, 3'b000});
  assign formed = bip_c >= need_m1;

  always_comb begin
    if (cfg.pixel_format == FMT_GRAY) begin
      pix = {24'd0, c_new[7:0]};
    end else if (cfg.pixel_format == FMT_BGR) begin
      pix = {8'd0, c_new[7:0], c_new[15:8], c_new[23:16]};
    end else begin
      pix = {c_new[31:24], c_new[7:0], c_new[15:8], c_new[23:16]};
    end
  end

  always_comb begin
    hdr_wait_nxt = hdr_wait_c;
    rem_nxt      = rem_c;
    rpt_nxt      = rpt_c;
    coll_nxt     = coll_c;
    bip_nxt      = bip_c;
    job.clear    = in_data.frame_start;
    job.pix      = pix;
    job.count    = 8'd0;
    if (!cfg.run_length_coded || !hdr_wait_c) begin
      if (formed) begin
        coll_nxt = 32'd0;
        bip_nxt  = 2'd0;
      end else begin
        coll_nxt = c_new;
        bip_nxt  = bip_c + 2'd1;
      end
    end
    if (!cfg.run_length_coded) begin
      if (formed) job.count = 8'd1;
    end else if (hdr_wait_c) begin
      if (b > RUN_BASE) begin
        rpt_nxt = 1'b1;
        rem_nxt = b - RUN_BASE;
      end else begin
        rpt_nxt = 1'b0;
        rem_nxt = b + 8'd1;
      end
      hdr_wait_nxt = 1'b0;
      coll_nxt     = 32'd0;
      bip_nxt      = 2'd0;
    end else if (formed) begin
      if (rpt_c) begin
        job.count    = rem_c;
        rem_nxt      = 8'd0;
        hdr_wait_nxt = 1'b1;
      end else begin
        job.count = 8'd1;
        rem_nxt   = rem_c - 8'd1;
        if (rem_c == 8'd1) hdr_wait_nxt = 1'b1;
      end
    end
  end

  // beats that change nothing downstream are not queued
  assign q_push = accept && (in_data.frame_start || job.count != 8'd0);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_wait_r <= 1'b1;
      rem_r      <= 8'd0;
      rpt_r      <= 1'b0;
      coll_r     <= 32'd0;
      bip_r      <= 2'd0;
    end else if (accept) begin
      hdr_wait_r <= hdr_wait_nxt;
      rem_r      <= rem_nxt;
      rpt_r      <= rpt_nxt;
      coll_r     <= coll_nxt;
      bip_r      <= bip_nxt;
    end
  end

endmodule

/* rtl/tgarle_queue.sv */
`timescale 1ns / 1ps

module tgarle_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tgarle_pkg::job_t push_job,
  output logic             full,
  input  logic             pop,
  output tgarle_pkg::job_t pop_job,
  output logic             empty
);
  import tgarle_pkg::*;

  job_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign full    = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign pop_job = slot_r[rd_ptr_r];

  // depth is a power of two, so pointers wrap on their own
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + 1'b1;
      if ((push && !full) && !(pop && !empty)) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

/* rtl/tgarle_back.sv */
`timescale 1ns / 1ps

module tgarle_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tgarle_pkg::cfg_t      cfg,
  input  logic                  q_empty,
  input  tgarle_pkg::job_t      q_job,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tgarle_pkg::out_data_t out_data
);
  import tgarle_pkg::*;

  typedef struct packed {
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] row;
    logic                ends_row;
    logic                done;
  } pos_t;

  function automatic pos_t step_pos(input logic [DIM_BITS-1:0] col,
                                    input logic [DIM_BITS-1:0] row,
                                    input logic [DIM_BITS-1:0] wid,
                                    input logic [DIM_BITS-1:0] hgt);
    pos_t p;
    p.ends_row = ((DIM_BITS+1)'(col) + 1'b1) >= (DIM_BITS+1)'(wid);
    p.col      = p.ends_row ? '0 : col + 1'b1;
    p.row      = p.ends_row ? row + 1'b1 : row;
    p.done     = p.ends_row && (p.row >= hgt || p.row == '0);
    return p;
  endfunction

  back_state_t         state_r, state_nxt;
  logic [31:0]         pix_r, pix_nxt;
  logic [7:0]          rem_r, rem_nxt, rem_after;
  logic [DIM_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic                done_r, done_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_data_t           out_data_r, out_data_nxt;

  logic slot_free, two, finish, done_eff;
  pos_t p1, p2;

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = (state_r == BK_IDLE) && !q_empty;
  assign done_eff  = q_job.clear ? 1'b0 : done_r;

  assign p1        = step_pos(col_r, row_r, cfg.image_width, cfg.image_height);
  assign p2        = step_pos(p1.col, p1.row, cfg.image_width, cfg.image_height);
  assign two       = (rem_r > 8'd1) && !p1.done;
  assign rem_after = rem_r - (two ? 8'd2 : 8'd1);
  assign finish    = p1.done || (two && p2.done) || rem_after == 8'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_pop && q_job.count != 8'd0 && !done_eff) state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free && finish) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pix_nxt       = pix_r;
    rem_nxt       = rem_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          pix_nxt = q_job.pix;
          rem_nxt = q_job.count;
          if (q_job.clear) begin
            col_nxt  = '0;
            row_nxt  = '0;
            done_nxt = 1'b0;
          end
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          rem_nxt  = rem_after;
          col_nxt  = two ? p2.col : p1.col;
          row_nxt  = two ? p2.row : p1.row;
          done_nxt = p1.done || (two && p2.done);
          out_valid_nxt                = 1'b1;
          out_data_nxt.first_pixel     = pix_r;
          out_data_nxt.second_pixel    = two ? pix_r : 32'd0;
          out_data_nxt.pixel_count     = two ? 2'd2 : 2'd1;
          out_data_nxt.first_ends_row  = p1.ends_row;
          out_data_nxt.second_ends_row = two && p2.ends_row;
          out_data_nxt.image_done      = p1.done || (two && p2.done);
          out_data_nxt.last_of_run     = finish;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.pixel_count == 2'd1 || out_data_r.pixel_count == 2'd2))
    else $error("result with bad pixel count");

  a_done_ends_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.image_done) |-> out_data_r.last_of_run)
    else $error("image end not flagged as last result of its beat");

  a_single_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.pixel_count == 2'd1) |->
      (out_data_r.second_pixel == 32'd0 && !out_data_r.second_ends_row))
    else $error("absent second pixel carries data");

  a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT) |-> (rem_r != 8'd0 && !done_r))
    else $error("emitting with no pixels left or image complete");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT && slot_free && out_data_nxt.image_done) |=> state_r == BK_IDLE)
    else $error("run continues past image end");

endmodule

/* rtl/tga_rle_pixel_decoder.sv */
`timescale 1ns / 1ps

// TGA pixel-data decoder: takes the byte stream after header, ID and color map,
// one byte per beat, in gray8, BGR24 or BGRA32, raw or run-length coded, and
// gives RGB(A) pixels up to two per result with row-end and image-end marks.
// Decoding stops at the configured height; a beat with frame_start restarts it.
// The front end takes one byte per cycle while its two-entry queue has room;
// header bytes and bytes that do not finish a pixel produce no result and are
// not queued, unless they carry frame_start. A beat that completes a pixel is
// written into the queue; the back end, while idle, takes it off into its pixel
// and count registers, then gives results of up to two pixels from a result
// register until the run is spent or the image ends, and only then takes the
// next beat off the queue. Once the queue fills, input stalls until the back
// end frees a slot. A stalled result holds the back end in place. Configuration
// is to be written only while the block is idle; the block does not enforce it.
module tga_rle_pixel_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tgarle_pkg::in_data_t             in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tgarle_pkg::out_data_t            out_data,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [tgarle_pkg::CFG_W-1:0]     cfg_data
);
  import tgarle_pkg::*;

  cfg_t cfg_r;
  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format     <= FMT_BGR;
      cfg_r.run_length_coded <= 1'b1;
      cfg_r.image_width      <= DIM_BITS'(1);
      cfg_r.image_height     <= DIM_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT: cfg_r.pixel_format     <= cfg_data[1:0];
        REG_RLE:    cfg_r.run_length_coded <= cfg_data[0];
        REG_WIDTH:  cfg_r.image_width      <= cfg_data[DIM_BITS-1:0];
        REG_HEIGHT: cfg_r.image_height     <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  tgarle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  tgarle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  tgarle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sim/tga_rle_pixel_decoder_test.sv */
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_test;
  import tgarle_pkg::*;

  localparam logic [1:0] FMT_ALPHA3 = 2'd3;   // spare code, decodes as BGRA
  localparam logic [7:0] REPEAT_MAX = 8'd255;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 40;
  localparam int MAX_RUN       = 128;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_data_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_data_t        out_data;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  tga_rle_pixel_decoder dut (.*);

  // Shadow of the configuration registers
  logic [1:0]  fmt_mirror;
  logic        rle_mirror;
  logic [15:0] width_mirror;
  logic [15:0] height_mirror;

  // Shadow of the decode state
  logic        in_packet;
  logic        packet_repeats;
  logic [7:0]  packet_left;
  logic [31:0] pixel_gather;
  logic [1:0]  gather_pos;
  logic [15:0] column_pos;
  logic [15:0] row_pos;
  logic        frame_finished;

  // Pixels produced by the current beat
  logic [31:0] beat_pixels[$];
  logic        beat_row_ends[$];
  logic        beat_frame_end;

  out_data_t expected_pairs[$];

  int mismatch_count = 0;
  int hold_request = 0;
  bit calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void clear_frame();
    in_packet      = 1'b0;
    packet_repeats = 1'b0;
    packet_left    = '0;
    pixel_gather   = '0;
    gather_pos     = '0;
    column_pos     = '0;
    row_pos        = '0;
    frame_finished = 1'b0;
  endfunction

  function automatic int bytes_per_pixel();
    if (fmt_mirror == FMT_GRAY) return 1;
    if (fmt_mirror == FMT_BGR) return 3;
    return 4;
  endfunction

  // Returns 1 once a whole pixel has been gathered, reordered to RGBA.
  function automatic bit gather_byte(input logic [7:0] b, output logic [31:0] pix);
    int need;
    need = bytes_per_pixel();
    pix = '0;
    pixel_gather |= 32'(b) << (8 * gather_pos);
    if (int'(gather_pos) + 1 < need) begin
      gather_pos = gather_pos + 2'd1;
      return 1'b0;
    end
    if (need == 1)
      pix = {24'd0, pixel_gather[7:0]};
    else
      pix = {(need == 4) ? pixel_gather[31:24] : 8'd0, pixel_gather[7:0],
             pixel_gather[15:8], pixel_gather[23:16]};
    pixel_gather = '0;
    gather_pos   = '0;
    return 1'b1;
  endfunction

  function automatic void place_pixel(input logic [31:0] pix);
    if (frame_finished || beat_pixels.size() >= MAX_RUN) return;
    beat_pixels.push_back(pix);
    if (int'(column_pos) + 1 >= int'(width_mirror)) begin
      beat_row_ends.push_back(1'b1);
      column_pos = '0;
      row_pos    = row_pos + 16'd1;
      // zero height, or a wrapped row counter, also ends the image
      if (row_pos >= height_mirror || row_pos == 16'd0) begin
        frame_finished = 1'b1;
        beat_frame_end = 1'b1;
      end
    end else begin
      beat_row_ends.push_back(1'b0);
      column_pos = column_pos + 16'd1;
    end
  endfunction

  function automatic void decode_beat(input in_data_t beat);
    logic [31:0] pix;
    int          n_res;
    out_data_t   res;
    beat_pixels.delete();
    beat_row_ends.delete();
    beat_frame_end = 1'b0;
    if (beat.frame_start) clear_frame();
    if (frame_finished) return;
    if (!rle_mirror) begin
      // raw bytes leave the packet phase alone
      if (gather_byte(beat.data_byte, pix)) place_pixel(pix);
    end else if (!in_packet) begin
      packet_repeats = beat.data_byte > RUN_BASE;
      packet_left    = packet_repeats ? beat.data_byte - RUN_BASE : beat.data_byte + 8'd1;
      in_packet      = 1'b1;
      pixel_gather   = '0;
      gather_pos     = '0;
    end else if (gather_byte(beat.data_byte, pix)) begin
      if (packet_repeats) begin
        for (int i = 0; i < int'(packet_left) && !frame_finished; i++) place_pixel(pix);
        packet_left = '0;
        in_packet   = 1'b0;
      end else begin
        place_pixel(pix);
        packet_left = packet_left - 8'd1;
        if (packet_left == 8'd0) in_packet = 1'b0;
      end
    end
    n_res = (beat_pixels.size() + 1) / 2;
    for (int k = 0; k < n_res; k++) begin
      res = '0;
      res.first_pixel    = beat_pixels[2 * k];
      res.first_ends_row = beat_row_ends[2 * k];
      res.pixel_count    = 2'd1;
      if (2 * k + 1 < beat_pixels.size()) begin
        res.second_pixel    = beat_pixels[2 * k + 1];
        res.second_ends_row = beat_row_ends[2 * k + 1];
        res.pixel_count     = 2'd2;
      end
      res.last_of_run = (k == n_res - 1);
      res.image_done  = res.last_of_run && beat_frame_end;
      expected_pairs.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
  endtask

  task automatic check_pair(input out_data_t got);
    out_data_t want;
    if (expected_pairs.size() == 0) begin
      report_mismatch("unexpected result", got.first_pixel, 32'd0);
      return;
    end
    want = expected_pairs.pop_front();
    if (got.first_pixel !== want.first_pixel)
      report_mismatch("first_pixel", got.first_pixel, want.first_pixel);
    if (got.second_pixel !== want.second_pixel)
      report_mismatch("second_pixel", got.second_pixel, want.second_pixel);
    if (got.pixel_count !== want.pixel_count)
      report_mismatch("pixel_count", 32'(got.pixel_count), 32'(want.pixel_count));
    if (got.first_ends_row !== want.first_ends_row)
      report_mismatch("first_ends_row", 32'(got.first_ends_row), 32'(want.first_ends_row));
    if (got.second_ends_row !== want.second_ends_row)
      report_mismatch("second_ends_row", 32'(got.second_ends_row),
                      32'(want.second_ends_row));
    if (got.image_done !== want.image_done)
      report_mismatch("image_done", 32'(got.image_done), 32'(want.image_done));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
  endtask

  // Result beats are checked before the input beat of the same edge is decoded.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_pair(out_data);
    if (rst_n && in_valid && in_ready) decode_beat(in_data);
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit fs = 1'b0);
    int gap;
    @(negedge clk);
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= '{data_byte: b, frame_start: fs};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pixel_bytes(input bit fs);
    int bpp;
    bpp = bytes_per_pixel();
    for (int i = 0; i < bpp; i++) send_byte(8'($urandom_range(0, 255)), fs && i == 0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    // header bytes and partial pixels give no result but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FORMAT: fmt_mirror    = value[1:0];
      REG_RLE:    rle_mirror    = value[0];
      REG_WIDTH:  width_mirror  = value;
      REG_HEIGHT: height_mirror = value;
      default: ;
    endcase
  endtask

  task automatic configure_image(input logic [1:0] fmt, input logic rle,
                                 input logic [15:0] w, input logic [15:0] h);
    wait_drained();
    write_reg(REG_FORMAT, CFG_W'(fmt));
    write_reg(REG_RLE, CFG_W'(rle));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Reset config is BGR, run-length, 1x1: one pixel completes the image.
  task automatic test_reset_config();
    send_byte(8'h00, 1'b1);
    send_byte(8'h10);
    send_byte(8'h20);
    send_byte(8'h30);
    send_byte(8'h81);   // image already done, dropped
  endtask

  // Longest repeat run with zero height: row of four ends the image, rest dropped.
  task automatic test_run_past_image_end();
    configure_image(FMT_GRAY, 1'b1, 16'd4, 16'd0);
    send_byte(REPEAT_MAX, 1'b1);
    send_byte(8'hFF);
  endtask

  // Format code 3 as BGRA, zero width, then a restart in the middle of a pixel.
  task automatic test_alpha_code_and_restart();
    configure_image(FMT_ALPHA3, 1'b1, 16'd0, 16'hFFFF);
    send_byte(8'h80, 1'b1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h7F);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h04);
  endtask

  // Mode flips inside a literal packet; the packet resumes afterwards.
  task automatic test_mode_switch();
    configure_image(FMT_GRAY, 1'b1, 16'd2, 16'd3);
    send_byte(8'h01, 1'b1);
    send_byte(8'h11);
    wait_drained();
    write_reg(REG_RLE, CFG_W'(1'b0));
    send_byte(8'h22);
    wait_drained();
    write_reg(REG_RLE, CFG_W'(1'b1));
    send_byte(8'h33);
    send_byte(8'h80);
  endtask

  task automatic test_backpressure();
    configure_image(FMT_GRAY, 1'b1, 16'd7, 16'hFFFF);
    @(posedge clk);
    hold_request = 400;
    for (int i = 0; i < 12; i++) begin
      send_byte(REPEAT_MAX, i == 0);
      send_pixel_bytes(1'b0);
    end
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      send_byte(8'($urandom_range(128, 255)));
      send_pixel_bytes(1'b0);
    end
  endtask

  task automatic test_random_streams();
    logic [15:0] w;
    logic [15:0] h;
    int          sent;
    int          n;
    bit          start;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 7))
        0:       w = 16'd0;
        1:       w = 16'hFFFF;
        default: w = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0:       h = 16'd0;
        1:       h = 16'hFFFF;
        default: h = 16'($urandom_range(1, 4));
      endcase
      configure_image(2'($urandom_range(0, 3)), ($urandom_range(0, 3) != 0), w, h);
      calm = (phase == 5) || ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 50) begin
        start = (sent == 0) || (frame_finished && $urandom_range(0, 3) != 0) ||
                ($urandom_range(0, 40) == 0);
        if ($urandom_range(0, 9) == 0) begin
          // stray byte: shifts packet or pixel alignment
          send_byte(8'($urandom_range(0, 255)), start);
          sent++;
        end else if (rle_mirror && $urandom_range(0, 1) == 1) begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_RUN) : $urandom_range(1, 6);
          send_byte(8'(n + 127), start);
          send_pixel_bytes(1'b0);
          sent += 1 + bytes_per_pixel();
        end else if (rle_mirror) begin
          n = $urandom_range(1, 4);
          send_byte(8'(n - 1), start);
          for (int i = 0; i < n; i++) send_pixel_bytes(1'b0);
          sent += 1 + n * bytes_per_pixel();
        end else begin
          send_pixel_bytes(start);
          sent += bytes_per_pixel();
        end
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_FORMAT;
    cfg_data  = '0;
    fmt_mirror    = FMT_BGR;
    rle_mirror    = 1'b1;
    width_mirror  = 16'd1;
    height_mirror = 16'd1;
    clear_frame();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_run_past_image_end();
    test_alpha_code_and_restart();
    test_mode_switch();
    test_backpressure();
    test_random_streams();

    wait_drained();
    if (mismatch_count == 0 && expected_pairs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* tga_rle_pixel_decoder.f */
rtl/tgarle_pkg.sv
rtl/tgarle_front.sv
rtl/tgarle_queue.sv
rtl/tgarle_back.sv
rtl/tga_rle_pixel_decoder.sv
sim/tga_rle_pixel_decoder_test.sv
